// ----- rtl/pcpd_pkg.sv -----
// Shared types and constants for the PWM period/duty capture block.
// Used by pcpd_ctrl, pcpd_dp and the pwm_capture_period_duty top level.
`default_nettype none

package pcpd_pkg;

  localparam int unsigned CapW   = 16;
  localparam int unsigned OvfW   = 16;
  localparam int unsigned StampW = OvfW + CapW;
  localparam int unsigned ShiftW = 3;
  localparam int unsigned DutyW  = 7;
  localparam int unsigned QuotW  = 7;
  localparam int unsigned NumW   = StampW + QuotW;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned PhaseW = 3;

  localparam logic [ShiftW-1:0] ShiftReset   = 3'd3;
  localparam logic [DutyW-1:0]  PercentScale = 7'd100;

  localparam logic [PhaseW-1:0] PhaseNone  = 3'd0;
  localparam logic [PhaseW-1:0] PhaseOne   = 3'd1;
  localparam logic [PhaseW-1:0] PhaseTwo   = 3'd2;
  localparam logic [PhaseW-1:0] PhaseThree = 3'd3;
  localparam logic [PhaseW-1:0] PhaseStop  = 3'd4;

  localparam logic ModeCapture  = 1'b0;
  localparam logic ModeOverflow = 1'b1;
  localparam logic EdgeRise     = 1'b0;
  localparam logic EdgeFall     = 1'b1;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StMul  = 5'b00010,
    StChk  = 5'b00100,
    StDiv  = 5'b01000,
    StFin  = 5'b10000
  } pcpd_state_e;

  typedef struct packed {
    logic            ovf_inc;
    logic            cap_t0;
    logic            cap_t1;
    logic            cap_t2;
    logic            mul;
    logic            chk;
    logic            div_step;
    logic [IdxW-1:0] bit_idx;
    logic            load_out;
    logic            out_result;
    logic            out_edge;
    logic            out_stop;
  } pcpd_cmd_t;

  typedef struct packed {
    logic span_zero;
    logic div_ge;
    logic out_busy;
  } pcpd_sts_t;

  function automatic logic awaited_edge(input logic [PhaseW-1:0] phase);
    logic e;
    if (phase >= PhaseThree) begin
      e = EdgeFall;
    end else begin
      e = phase[0];
    end
    return e;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/pwm_capture_period_duty.sv -----
// Ticks and all captures but the third give their transaction in the cycle after
// acceptance; the third capture runs multiply, range check, 7 divide steps and
// output load, without the divide steps when the span is zero or the quotient
// reaches 128 (saturated). One event per cycle while no third capture is in flight.
// Output stall holds the output register and delays acceptance by the stalled cycles.
// Reset: asynchronous; clears phase, overflow count and output valid; period_shift = 3.
`default_nettype none

module pwm_capture_period_duty (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pcpd_pkg::ShiftW-1:0]      cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             mode_i,
  input  logic [pcpd_pkg::CapW-1:0]        capture_value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             edge_select_o,
  output logic                             result_valid_o,
  output logic [pcpd_pkg::StampW-1:0]      period_units_o,
  output logic [pcpd_pkg::DutyW-1:0]       duty_percent_o,
  output logic                             zero_span_o,
  output logic                             stopped_o
);
  import pcpd_pkg::*;

  pcpd_cmd_t cmd;
  pcpd_sts_t sts;

  pcpd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pcpd_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .capture_value_i (capture_value_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .edge_select_o   (edge_select_o),
    .result_valid_o  (result_valid_o),
    .period_units_o  (period_units_o),
    .duty_percent_o  (duty_percent_o),
    .zero_span_o     (zero_span_o),
    .stopped_o       (stopped_o)
  );

endmodule

`default_nettype wire

// ----- rtl/pcpd_ctrl.sv -----
// Controller: capture phase tracking, input handshake and divide sequencing.
// Depends on pcpd_pkg; drives pcpd_dp through pcpd_cmd_t.
`default_nettype none

module pcpd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                mode_i,
  input  pcpd_pkg::pcpd_sts_t sts_i,
  output pcpd_pkg::pcpd_cmd_t cmd_o
);
  import pcpd_pkg::*;

  pcpd_state_e       state_q, state_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic              idle_free;
  logic              accept;
  logic              stopped;
  logic              capture;

  assign idle_free  = (state_q == StIdle) && !sts_i.out_busy;
  assign in_stall_o = !idle_free;
  assign accept     = idle_free && in_valid_i;
  assign stopped    = (phase_q == PhaseStop);
  assign capture    = accept && (mode_i == ModeCapture) && !stopped;

  always_comb begin
    state_d       = state_q;
    phase_d       = phase_q;
    idx_d         = idx_q;
    cmd_o         = '0;
    cmd_o.bit_idx = idx_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          cmd_o.ovf_inc = (mode_i == ModeOverflow) && !stopped;
          if (capture) begin
            phase_d      = phase_q + 3'd1;
            cmd_o.cap_t0 = (phase_q == PhaseNone);
            cmd_o.cap_t1 = (phase_q == PhaseOne);
            cmd_o.cap_t2 = (phase_q == PhaseTwo);
          end
          if (capture && (phase_q == PhaseTwo)) begin
            state_d = StMul;
          end else begin
            cmd_o.load_out = 1'b1;
            cmd_o.out_edge = awaited_edge(phase_d);
            cmd_o.out_stop = (phase_d == PhaseStop);
          end
        end
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        idx_d     = IdxW'(QuotW);
        state_d   = StChk;
      end
      StChk: begin
        cmd_o.chk = 1'b1;
        if (sts_i.span_zero || sts_i.div_ge) begin
          state_d = StFin;
        end else begin
          idx_d   = idx_q - 3'd1;
          state_d = StDiv;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (idx_q == '0) begin
          state_d = StFin;
        end else begin
          idx_d = idx_q - 3'd1;
        end
      end
      StFin: begin
        if (!sts_i.out_busy) begin
          cmd_o.load_out   = 1'b1;
          cmd_o.out_result = 1'b1;
          cmd_o.out_edge   = awaited_edge(phase_q);
          cmd_o.out_stop   = (phase_q == PhaseStop);
          state_d          = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      phase_q <= PhaseNone;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      idx_q   <= idx_d;
    end
  end

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PhaseStop)
    else $error("capture phase out of range");

  a_third_starts_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    capture && (phase_q == PhaseTwo) |=> (state_q == StMul) && (phase_q == PhaseThree))
    else $error("third capture did not start the duty computation");

  a_div_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |=> (state_q == StDiv) || (state_q == StFin))
    else $error("divide sequence left early");

endmodule

`default_nettype wire

// ----- rtl/pcpd_dp.sv -----
// Datapath: overflow count, stamps, spans, restoring divider and output register.
// Depends on pcpd_pkg; controlled by pcpd_ctrl through pcpd_cmd_t.
`default_nettype none

module pcpd_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pcpd_pkg::pcpd_cmd_t              cmd_i,
  output pcpd_pkg::pcpd_sts_t              sts_o,
  input  logic [pcpd_pkg::CapW-1:0]        capture_value_i,
  input  logic                             cfg_we_i,
  input  logic [pcpd_pkg::ShiftW-1:0]      cfg_wdata_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             edge_select_o,
  output logic                             result_valid_o,
  output logic [pcpd_pkg::StampW-1:0]      period_units_o,
  output logic [pcpd_pkg::DutyW-1:0]       duty_percent_o,
  output logic                             zero_span_o,
  output logic                             stopped_o
);
  import pcpd_pkg::*;

  logic [OvfW-1:0]   ovf_q;
  logic [ShiftW-1:0] shift_q;
  logic              out_valid_q, out_valid_d;
  logic [StampW-1:0] t0_q, t1_q;
  logic [StampW-1:0] span_all_q, span_high_q;
  logic [NumW-1:0]   rem_q;
  logic [QuotW-1:0]  quot_q;
  logic              sat_q;

  logic [StampW-1:0] stamp;
  logic [NumW-1:0]   divisor;
  logic [NumW-1:0]   product;
  logic              div_ge;
  logic [DutyW-1:0]  duty_calc;
  logic              span_zero;

  assign stamp     = {ovf_q, capture_value_i};
  assign divisor   = NumW'(span_all_q) << cmd_i.bit_idx;
  assign product   = NumW'(span_high_q) * NumW'(PercentScale);
  assign div_ge    = (rem_q >= divisor);
  assign span_zero = (span_all_q == '0);
  assign duty_calc = (sat_q || (quot_q > PercentScale)) ? PercentScale : quot_q;

  assign sts_o.span_zero = span_zero;
  assign sts_o.div_ge    = div_ge;
  assign sts_o.out_busy  = out_valid_q && out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_q       <= '0;
      shift_q     <= ShiftReset;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cmd_i.ovf_inc) begin
        ovf_q <= ovf_q + 16'd1;
      end
      if (cfg_we_i) begin
        shift_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_t0) begin
      t0_q <= stamp;
    end
    if (cmd_i.cap_t1) begin
      t1_q <= stamp;
    end
    if (cmd_i.cap_t2) begin
      span_all_q  <= stamp - t0_q;
      span_high_q <= stamp - t1_q;
    end
    if (cmd_i.mul) begin
      rem_q <= product;
    end
    if (cmd_i.chk) begin
      sat_q  <= div_ge;
      quot_q <= '0;
    end
    if (cmd_i.div_step && div_ge) begin
      rem_q                 <= rem_q - divisor;
      quot_q[cmd_i.bit_idx] <= 1'b1;
    end
    if (cmd_i.load_out) begin
      edge_select_o  <= cmd_i.out_edge;
      stopped_o      <= cmd_i.out_stop;
      result_valid_o <= cmd_i.out_result;
      if (cmd_i.out_result && !span_zero) begin
        period_units_o <= span_all_q >> shift_q;
        duty_percent_o <= duty_calc;
        zero_span_o    <= 1'b0;
      end else begin
        period_units_o <= '0;
        duty_percent_o <= '0;
        zero_span_o    <= cmd_i.out_result;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> duty_percent_o <= PercentScale)
    else $error("duty above full scale");

  a_zero_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_span_o |->
      result_valid_o && (duty_percent_o == '0) && (period_units_o == '0))
    else $error("zero span result carries data");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_o.out_busy |-> !cmd_i.load_out)
    else $error("pending transaction overwritten");

endmodule

`default_nettype wire
